// ===== hw/rtl/riff_qcp_header_checker_top_assert.svh =====
// Assertion macros for the QCP header checker.
// Used by the checker module that is bound to the top level.
`ifndef RIFF_QCP_HEADER_CHECKER_TOP_ASSERT_SVH
`define RIFF_QCP_HEADER_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define RQHC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define RQHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define RQHC_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rqhc_pkg.sv =====
// Shared types and constants for the QCP header checker.
// No dependencies; imported by the top level and the checker.
package rqhc_pkg;

   localparam int POS_W  = 34;
   localparam int BODY_W = 35;

   localparam logic [31:0] RIFF_TAG    = 32'h5249_4646;
   localparam logic [31:0] QLCM_TAG    = 32'h514C_434D;
   localparam logic [31:0] FMT_TAG     = 32'h666D_7420;
   localparam logic [31:0] DATA_TAG    = 32'h6461_7461;
   localparam logic [31:0] FMT_MIN_LEN = 32'd18;

   // Offset just past the first chunk header (first chunk at 12, header is 8).
   localparam logic [BODY_W-1:0] FIRST_BODY = 35'd20;
   localparam logic [32:0]       EMPTY_END  = 33'd8;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_TAGS,
      ERR_SIZE,
      ERR_CHUNK,
      ERR_PAD,
      ERR_TRAIL,
      ERR_NO_FMT,
      ERR_NO_DATA
   } err_code_type;

   // Everything the verdict needs, captured on the last byte of a file.
   typedef struct packed {
      logic [BODY_W-1:0] size;
      logic              tags;
      logic [31:0]       declared;
      err_code_type      werr;
      logic [BODY_W-1:0] body;
      logic              fmt_ok;
      logic              data_ok;
   } pend_type;

   // Byte idx of a four-character tag, first character at idx 0.
   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
      logic [7:0] res;
      case (idx)
         2'd0: res = tag[31:24];
         2'd1: res = tag[23:16];
         2'd2: res = tag[15:8];
         default: res = tag[7:0];
      endcase
      return res;
   endfunction

endpackage

// ===== hw/rtl/riff_qcp_header_checker_top.sv =====
// Top level of the streaming QCP (RIFF/QLCM) header and chunk checker.
// Depends on rqhc_pkg.
//
//   channel | direction | word                          | handshake
//   req     | in        | data_byte, is_last            | req_valid / req_stall
//   rsp     | out       | valid_res, error_code (3 bits)| rsp_valid / rsp_stall
//
// One byte is taken every cycle while req_stall is low; the per-byte work is a
// 35-bit add and compare in the chunk walk. The last byte of a file captures the
// final state; the verdict is then evaluated and registered when the output is free.
// Reset is synchronous and returns the walk to the start of a new file.
// req_stall rises only while a verdict is pending and the output word is held.
module riff_qcp_header_checker_top
   import rqhc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res,
   output logic [2:0] rsp_error_code
);

   // Walk state.
   logic [POS_W-1:0]  pos_ff;
   logic              tags_ff, tags_in;
   logic [31:0]       ds_ff, ds_in;
   logic [32:0]       fim_ff;
   logic [63:0]       shift_ff;
   logic [BODY_W-1:0] body_ff, body_in;
   logic              fmt_ff, fmt_in;
   logic              data_ff, data_in;
   err_code_type      werr_ff, werr_in;

   // Pending verdict and output word.
   logic              pend_valid_ff;
   pend_type          pend_ff, pend_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_res_ff;
   err_code_type      rsp_code_ff, code_in;

   logic              accept, out_free, pend_move;
   logic [63:0]       hdr;
   logic [31:0]       tag, n;
   logic [BODY_W-1:0] pos_p1, sum, fim_w;
   logic              take;

   // Handshake control.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_move = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Header fields as seen once the current byte is shifted in.
   assign hdr    = {shift_ff[55:0], req_data_byte};
   assign tag    = hdr[63:32];
   assign n      = {hdr[7:0], hdr[15:8], hdr[23:16], hdr[31:24]};
   assign pos_p1 = {1'b0, pos_ff} + 35'd1;
   assign fim_w  = {2'b00, fim_ff};
   assign sum    = body_ff + {3'b000, n};
   assign take   = (werr_ff == ERR_NONE) && (pos_ff >= 34'd8) && (body_ff <= fim_w)
                   && (pos_p1 == body_ff);

   // Next walk state for the byte on the input.
   always_comb begin
      tags_in = tags_ff;
      ds_in   = ds_ff;
      body_in = body_ff;
      fmt_in  = fmt_ff;
      data_in = data_ff;
      werr_in = werr_ff;
      if (pos_ff < 34'd4) begin
         if (req_data_byte != tag_byte(RIFF_TAG, pos_ff[1:0])) tags_in = 1'b0;
      end else if (pos_ff < 34'd8) begin
         ds_in[{pos_ff[1:0], 3'b000} +: 8] = req_data_byte;
      end else if (pos_ff < 34'd12) begin
         if (req_data_byte != tag_byte(QLCM_TAG, pos_ff[1:0])) tags_in = 1'b0;
      end
      if (take) begin
         if (sum > fim_w) begin
            werr_in = ERR_CHUNK;
         end else begin
            if (tag == FMT_TAG) fmt_in = (n >= FMT_MIN_LEN);
            if (tag == DATA_TAG) data_in = (n != 32'd0);
            body_in = sum + {34'd0, n[0]} + 35'd8;
            if (n[0] && (sum == fim_w)) werr_in = ERR_PAD;
         end
      end
      pend_in.size     = pos_p1;
      pend_in.tags     = tags_in;
      pend_in.declared = ds_in;
      pend_in.werr     = werr_in;
      pend_in.body     = body_in;
      pend_in.fmt_ok   = fmt_in;
      pend_in.data_ok  = data_in;
   end

   // Verdict from the captured final state, in order of precedence.
   always_comb begin
      if ((pend_ff.size < 35'd12) || !pend_ff.tags) begin
         code_in = ERR_TAGS;
      end else if ((pend_ff.declared < 32'd4)
                   || (({3'b000, pend_ff.declared} + 35'd8) > pend_ff.size)) begin
         code_in = ERR_SIZE;
      end else if (pend_ff.werr != ERR_NONE) begin
         code_in = pend_ff.werr;
      end else if (pend_ff.body != ({3'b000, pend_ff.declared} + 35'd16)) begin
         code_in = ERR_TRAIL;
      end else if (!pend_ff.fmt_ok) begin
         code_in = ERR_NO_FMT;
      end else if (!pend_ff.data_ok) begin
         code_in = ERR_NO_DATA;
      end else begin
         code_in = ERR_NONE;
      end
   end

   // Walk state registers; the last byte of a file restarts the walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         tags_ff  <= 1'b1;
         ds_ff    <= '0;
         fim_ff   <= EMPTY_END;
         shift_ff <= '0;
         body_ff  <= FIRST_BODY;
         fmt_ff   <= 1'b0;
         data_ff  <= 1'b0;
         werr_ff  <= ERR_NONE;
      end else begin
         // The declared end is registered from the size; it is first used well later.
         fim_ff <= {1'b0, ds_ff} + 33'd8;
         if (accept) begin
            if (req_is_last) begin
               pos_ff   <= '0;
               tags_ff  <= 1'b1;
               ds_ff    <= '0;
               shift_ff <= '0;
               body_ff  <= FIRST_BODY;
               fmt_ff   <= 1'b0;
               data_ff  <= 1'b0;
               werr_ff  <= ERR_NONE;
            end else begin
               if (pos_ff != '1) pos_ff <= pos_p1[POS_W-1:0];
               tags_ff  <= tags_in;
               ds_ff    <= ds_in;
               shift_ff <= hdr;
               body_ff  <= body_in;
               fmt_ff   <= fmt_in;
               data_ff  <= data_in;
               werr_ff  <= werr_in;
            end
         end
      end
   end

   // Pending verdict capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept && req_is_last) begin
         pend_valid_ff <= 1'b1;
      end else if (pend_move) begin
         pend_valid_ff <= 1'b0;
      end
      if (accept && req_is_last) pend_ff <= pend_in;
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (pend_move) begin
         rsp_code_ff      <= code_in;
         rsp_valid_res_ff <= (code_in == ERR_NONE);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = rsp_valid_res_ff;
   assign rsp_error_code = rsp_code_ff;

endmodule

// ===== hw/rtl/rqhc_checker.sv =====
// Port-level assertions for the QCP header checker, bound to the top level.
// Depends on rqhc_pkg and riff_qcp_header_checker_top_assert.svh.
`include "riff_qcp_header_checker_top_assert.svh"

module rqhc_checker
   import rqhc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_valid_res,
   input logic [2:0] rsp_error_code
);

   // A held output word keeps its contents.
   `RQHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_error_code) && $stable(rsp_valid_res), "rsp word changed while stalled")

   // The pass flag agrees with the error code.
   `RQHC_ASSERT_NOW(a_res_matches_code, rsp_valid, rsp_valid_res == (rsp_error_code == ERR_NONE), "valid_res disagrees with error_code")

   // The input stalls only when a verdict is queued behind a held output word.
   `RQHC_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled with output free")

   // A fresh verdict is traced back to an accepted last byte.
   `RQHC_ASSERT_NOW(a_rsp_source, $rose(rsp_valid), $past(req_valid && !req_stall && req_is_last, 2), "verdict without a last byte")

   // Reset empties the output.
   `RQHC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "output valid after reset")

endmodule

bind riff_qcp_header_checker_top rqhc_checker u_rqhc_checker (.*);
